// File: rtl/mts_pkg.sv
// Shared types and constants of the min tracking stack.
package mts_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] min_value;
    logic [COUNT_W-1:0]       item_count;
    status_e                  status;
  } rsp_t;

endpackage

// File: rtl/mts_if.sv
// Request and response channel interfaces of the min tracking stack.
interface mts_req_if;
  logic                               valid;
  logic                               ready;
  mts_pkg::req_e                      req_type;
  logic signed [mts_pkg::DATA_W-1:0]  push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface mts_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [mts_pkg::DATA_W-1:0]  popped_value;
  logic signed [mts_pkg::DATA_W-1:0]  min_value;
  logic [mts_pkg::COUNT_W-1:0]        item_count;
  logic [mts_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output popped_value, output min_value,
                  output item_count, output status, input ready);
  modport sink   (input valid, input popped_value, input min_value,
                  input item_count, input status, output ready);
endinterface

// File: rtl/mts_mem.sv
// Single-port-write, single-port-read memory with registered read data.
module mts_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/min_tracking_stack_top.sv
// Top level of the min tracking stack: control, top-of-stack registers and two stores.
//
// A LIFO stack of signed 32-bit values that reports its current minimum with every
// result. Each request is a push or a pop and yields exactly one response carrying the
// popped value, the minimum after the step (0 when empty), the item count and a status
// (ok, pop on empty, push on full). The top value and the current minimum sit in
// registers; the value store and a second store of running minima are synchronous
// memories. A push, a push on a full stack and a pop on an empty stack load the response
// register at acceptance, so pushes can stream one per cycle while responses drain. A pop
// first passes through the refill state, which waits for the memory read that refills the
// top-of-stack registers. A new request is taken once the control is idle and the response
// register is empty or being drained in the same cycle. Item count is reported modulo 128.
module min_tracking_stack_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mts_req_if.sink   req_i,
  mts_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REFILL = 1'b1;

  logic                              state_q, state_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [CntW-1:0]                   mcnt_q, mcnt_d;
  logic signed [mts_pkg::DATA_W-1:0] top_val_q, top_val_d;
  logic signed [mts_pkg::DATA_W-1:0] cur_min_q, cur_min_d;
  logic signed [mts_pkg::DATA_W-1:0] pop_val_q, pop_val_d;
  logic                              drop_q, drop_d;
  logic                              rsp_valid_q, rsp_valid_d;
  mts_pkg::rsp_t                     rsp_q, rsp_d;

  logic                       accept;
  logic                       full;
  logic                       min_push;
  logic [CntW-1:0]            cnt_inc, cnt_dec, cnt_m2;
  logic [CntW-1:0]            mcnt_inc, mcnt_dec, mcnt_m2;
  logic                       val_we, min_we, mem_re;
  logic [mts_pkg::DATA_W-1:0] val_rdata, min_rdata;

  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign full     = (cnt_q == CntW'(STACK_DEPTH));
  assign min_push = (mcnt_q == '0) || (req_i.push_value <= cur_min_q);
  assign cnt_inc  = cnt_q + CntW'(1);
  assign cnt_dec  = cnt_q - CntW'(1);
  assign cnt_m2   = cnt_q - CntW'(2);
  assign mcnt_inc = mcnt_q + CntW'(1);
  assign mcnt_dec = mcnt_q - CntW'(1);
  assign mcnt_m2  = mcnt_q - CntW'(2);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mcnt_d      = mcnt_q;
    top_val_d   = top_val_q;
    cur_min_d   = cur_min_q;
    pop_val_d   = pop_val_q;
    drop_d      = drop_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    val_we      = 1'b0;
    min_we      = 1'b0;
    mem_re      = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == mts_pkg::REQ_PUSH) begin
            rsp_valid_d        = 1'b1;
            rsp_d.popped_value = '0;
            if (full) begin
              rsp_d.min_value  = cur_min_q;
              rsp_d.item_count = mts_pkg::COUNT_W'(cnt_q);
              rsp_d.status     = mts_pkg::STATUS_FULL;
            end else begin
              val_we    = 1'b1;
              top_val_d = req_i.push_value;
              cnt_d     = cnt_inc;
              if (min_push) begin
                min_we    = 1'b1;
                cur_min_d = req_i.push_value;
                mcnt_d    = mcnt_inc;
              end
              rsp_d.min_value  = min_push ? req_i.push_value : cur_min_q;
              rsp_d.item_count = mts_pkg::COUNT_W'(cnt_inc);
              rsp_d.status     = mts_pkg::STATUS_OK;
            end
          end else if (cnt_q == '0) begin
            rsp_valid_d        = 1'b1;
            rsp_d.popped_value = '0;
            rsp_d.min_value    = '0;
            rsp_d.item_count   = '0;
            rsp_d.status       = mts_pkg::STATUS_EMPTY;
          end else begin
            // fetch the entries below the top to refill the registers
            mem_re    = 1'b1;
            pop_val_d = top_val_q;
            drop_d    = (top_val_q == cur_min_q);
            cnt_d     = cnt_dec;
            if (top_val_q == cur_min_q) begin
              mcnt_d = mcnt_dec;
            end
            state_d = ST_REFILL;
          end
        end
      end
      ST_REFILL: begin
        top_val_d = val_rdata;
        if (drop_q) begin
          cur_min_d = min_rdata;
        end
        rsp_valid_d        = 1'b1;
        rsp_d.popped_value = pop_val_q;
        rsp_d.min_value    = (cnt_q == '0) ? '0 : (drop_q ? min_rdata : cur_min_q);
        rsp_d.item_count   = mts_pkg::COUNT_W'(cnt_q);
        rsp_d.status       = mts_pkg::STATUS_OK;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mcnt_q      <= '0;
      drop_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mcnt_q      <= mcnt_d;
      drop_q      <= drop_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q <= top_val_d;
    cur_min_q <= cur_min_d;
    pop_val_q <= pop_val_d;
    rsp_q     <= rsp_d;
  end

  mts_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (mts_pkg::DATA_W)
  ) u_val_mem (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (req_i.push_value),
    .re_i    (mem_re),
    .raddr_i (cnt_m2[AddrW-1:0]),
    .rdata_o (val_rdata)
  );

  mts_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (mts_pkg::DATA_W)
  ) u_min_mem (
    .clk_i   (clk_i),
    .we_i    (min_we),
    .waddr_i (mcnt_q[AddrW-1:0]),
    .wdata_i (req_i.push_value),
    .re_i    (mem_re),
    .raddr_i (mcnt_m2[AddrW-1:0]),
    .rdata_o (min_rdata)
  );

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.popped_value = rsp_q.popped_value;
  assign rsp_o.min_value    = rsp_q.min_value;
  assign rsp_o.item_count   = rsp_q.item_count;
  assign rsp_o.status       = rsp_q.status;

endmodule

// File: rtl/mts_checker.sv
// Port-level assertions of the min tracking stack, bound to the top level.
module mts_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic signed [mts_pkg::DATA_W-1:0] popped_value_i,
  input logic signed [mts_pkg::DATA_W-1:0] min_value_i,
  input logic [mts_pkg::COUNT_W-1:0]       item_count_i,
  input logic [mts_pkg::STATUS_W-1:0]      status_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = req_valid_i && req_ready_i;
  assign out_acc = rsp_valid_i && rsp_ready_i;

  // items taken but whose response has not yet been delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(popped_value_i) &&
      $stable(min_value_i) && $stable(item_count_i) && $stable(status_i))
    else $error("response changed while stalled");

  a_rsp_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("response without an accepted item");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 || pend_q == 2'd1)
    else $error("more than one item in flight");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == mts_pkg::STATUS_EMPTY |->
      popped_value_i == '0 && min_value_i == '0 && item_count_i == '0)
    else $error("empty pop response not cleared");

  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == mts_pkg::STATUS_FULL |-> popped_value_i == '0)
    else $error("full push reports a popped value");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .popped_value_i (rsp_o.popped_value),
  .min_value_i    (rsp_o.min_value),
  .item_count_i   (rsp_o.item_count),
  .status_i       (rsp_o.status)
);
